@@ design/iol_pkg.sv @@
// iol_pkg: shared types, field widths and codes for the indexed ordered list.
// No dependencies; compiled first.
package iol_pkg;

  localparam int unsigned CAPACITY_DEF = 16;

  localparam int unsigned VAL_W  = 32;
  localparam int unsigned POS_W  = 4;
  localparam int unsigned ACT_W  = 3;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned CNT_W  = 5;

  // action codes
  localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_PUSH_END   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_INSERT     = 3'd2;
  localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_POP_END    = 3'd4;
  localparam logic [ACT_W-1:0] ACT_ERASE      = 3'd5;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_OPEN,
    OP_CLOSE
  } op_kind_e;

  // decoded operation handed from decode to the cell row
  typedef struct packed {
    op_kind_e            kind;
    logic [STAT_W-1:0]   status;
  } op_t;

  typedef struct packed {
    logic [ACT_W-1:0]        action;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] item_value;
  } cmd_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] removed_value;
    logic [STAT_W-1:0]       status;
    logic [CNT_W-1:0]        entry_count;
    logic signed [VAL_W-1:0] front_value;
    logic signed [VAL_W-1:0] end_value;
  } rsp_t;

endpackage

@@ design/iol_if.sv @@
// iol_if: valid/ready channel interfaces for command and response words.
// Depends on iol_pkg for the payload structs.
interface iol_cmd_if import iol_pkg::*; ();
  logic valid;
  logic ready;
  cmd_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface iol_rsp_if import iol_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ design/iol_decode.sv @@
// iol_decode: checks one command against the current count and picks the
// cell-row operation, its index and the status. Depends on iol_pkg.
module iol_decode import iol_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF,
  localparam int unsigned OCC_W = $clog2(CAPACITY + 1),
  localparam int unsigned IDX_W = $clog2(CAPACITY)
) (
  input  logic [ACT_W-1:0] action_i,
  input  logic [POS_W-1:0] position_i,
  input  logic [OCC_W-1:0] occ_i,
  output op_t              op_o,
  output logic [IDX_W-1:0] at_o
);

  localparam int unsigned CMP_W = (OCC_W > POS_W) ? OCC_W : POS_W;

  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] occ_ext;
  logic             is_empty;
  logic             is_full;
  logic             bad_idx;
  logic [IDX_W-1:0] pos_idx;
  logic [IDX_W-1:0] last_idx;
  logic [IDX_W-1:0] tail_idx;

  assign pos_ext  = CMP_W'(position_i);
  assign occ_ext  = CMP_W'(occ_i);
  assign is_empty = (occ_i == '0);
  assign is_full  = (occ_i == OCC_W'(CAPACITY));
  assign bad_idx  = (pos_ext >= occ_ext);
  // only used when the index is known to be below the count
  assign pos_idx  = IDX_W'(pos_ext);
  assign last_idx = IDX_W'(occ_i - OCC_W'(1));
  assign tail_idx = IDX_W'(occ_i);

  always_comb begin
    op_o.kind   = OP_NONE;
    op_o.status = ST_OK;
    at_o        = '0;
    case (action_i)
      ACT_PUSH_FRONT: begin
        if (is_full) op_o.status = ST_FULL;
        else op_o.kind = OP_OPEN;
      end
      ACT_PUSH_END: begin
        if (is_full) begin
          op_o.status = ST_FULL;
        end else begin
          op_o.kind = OP_OPEN;
          at_o      = tail_idx;
        end
      end
      ACT_INSERT: begin
        if (is_empty) begin
          op_o.status = ST_EMPTY;
        end else if (bad_idx) begin
          op_o.status = ST_RANGE;
        end else if (is_full) begin
          op_o.status = ST_FULL;
        end else begin
          op_o.kind = OP_OPEN;
          at_o      = pos_idx;
        end
      end
      ACT_POP_FRONT: begin
        if (is_empty) op_o.status = ST_EMPTY;
        else op_o.kind = OP_CLOSE;
      end
      ACT_POP_END: begin
        if (is_empty) begin
          op_o.status = ST_EMPTY;
        end else begin
          op_o.kind = OP_CLOSE;
          at_o      = last_idx;
        end
      end
      ACT_ERASE: begin
        if (is_empty) begin
          op_o.status = ST_EMPTY;
        end else if (bad_idx) begin
          op_o.status = ST_RANGE;
        end else begin
          op_o.kind = OP_CLOSE;
          at_o      = pos_idx;
        end
      end
      default: begin
        op_o.kind = OP_NONE;
      end
    endcase
  end

endmodule

@@ design/iol_cells.sv @@
// iol_cells: row of value cells plus the entry count; opens or closes a slot
// by shifting the cells past the slot one place in parallel. Depends on iol_pkg.
module iol_cells import iol_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF,
  localparam int unsigned OCC_W = $clog2(CAPACITY + 1),
  localparam int unsigned IDX_W = $clog2(CAPACITY)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  op_t              op_i,
  input  logic [IDX_W-1:0] at_i,
  input  logic [VAL_W-1:0] val_i,
  output logic [OCC_W-1:0] occ_o,
  output logic [OCC_W-1:0] occ_next_o,
  output logic [VAL_W-1:0] removed_o,
  output logic [VAL_W-1:0] front_o,
  output logic [VAL_W-1:0] end_o
);

  logic [VAL_W-1:0] cell_q [CAPACITY];
  logic [VAL_W-1:0] cell_d [CAPACITY];
  logic [OCC_W-1:0] occ_q;
  logic [OCC_W-1:0] occ_d;
  logic [IDX_W-1:0] end_idx;

  always_comb begin
    occ_d     = occ_q;
    removed_o = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      cell_d[i] = cell_q[i];
    end
    case (op_i.kind)
      OP_OPEN: begin
        occ_d = occ_q + OCC_W'(1);
        for (int i = 0; i < CAPACITY; i++) begin
          if (IDX_W'(i) == at_i) cell_d[i] = val_i;
          else if (IDX_W'(i) > at_i) cell_d[i] = cell_q[(i > 0) ? i - 1 : 0];
        end
      end
      OP_CLOSE: begin
        occ_d     = occ_q - OCC_W'(1);
        removed_o = cell_q[at_i];
        for (int i = 0; i < CAPACITY; i++) begin
          if (IDX_W'(i) >= at_i) cell_d[i] = cell_q[(i < CAPACITY - 1) ? i + 1 : i];
        end
      end
      default: begin
        occ_d = occ_q;
      end
    endcase
  end

  // new end sits at count-1 after the update; only read when non-empty
  assign end_idx    = IDX_W'(occ_d - OCC_W'(1));
  assign front_o    = (occ_d != '0) ? cell_d[0] : '0;
  assign end_o      = (occ_d != '0) ? cell_d[end_idx] : '0;
  assign occ_o      = occ_q;
  assign occ_next_o = occ_d;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < CAPACITY; i++) begin
        cell_q[i] <= cell_d[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else if (en_i) begin
      occ_q <= occ_d;
    end
  end

endmodule

@@ design/indexed_ordered_list_top.sv @@
// indexed_ordered_list_top: bounded ordered list of signed 32-bit values.
// Depends on iol_pkg, iol_if, iol_decode and iol_cells.
//
// Usage:
//   cmd_i carries one command word per handshake: action, position, item_value.
//   rsp_o returns exactly one response word per command, in order: removed
//   value, status, count, front and end value after the action.
//   Actions: push front, push end, insert at index, pop front, pop end,
//   erase at index. Errors leave the list untouched and report a status.
// Timing:
//   An accepted command lands in the command register; when it advances,
//   the cell row updates and the response register loads at the same edge,
//   so rsp_o.valid rises then. One command per cycle is sustained while
//   rsp_o.ready stays high: every insert or remove shifts the affected
//   cells at once.
// Stall:
//   The response register holds its word while rsp_o.ready is low; the
//   command register then also holds, and cmd_i.ready drops once both are
//   occupied. Nothing is dropped or repeated.
// Reset:
//   rst_ni clears the count and both valid flags; cell contents are only
//   read below the count, so they need no clearing.
module indexed_ordered_list_top import iol_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input logic      clk_i,
  input logic      rst_ni,
  iol_cmd_if.sink   cmd_i,
  iol_rsp_if.source rsp_o
);

  localparam int unsigned OCC_W = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W = $clog2(CAPACITY);

  // command register
  logic cmd_vld_q;
  cmd_t cmd_q;
  // response register
  logic rsp_vld_q;
  logic rsp_vld_d;
  rsp_t rsp_q;
  rsp_t rsp_d;

  logic             advance;  // command register moves into response register
  op_t              op;
  logic [IDX_W-1:0] at;
  logic [OCC_W-1:0] occ;
  logic [OCC_W-1:0] occ_next;
  logic [VAL_W-1:0] removed;
  logic [VAL_W-1:0] front;
  logic [VAL_W-1:0] last;

  assign advance     = cmd_vld_q && (!rsp_vld_q || rsp_o.ready);
  assign cmd_i.ready = !cmd_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_vld_q <= 1'b0;
    end else if (cmd_i.ready) begin
      cmd_vld_q <= cmd_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ready && cmd_i.valid) begin
      cmd_q <= cmd_i.data;
    end
  end

  iol_decode #(
    .CAPACITY (CAPACITY)
  ) u_decode (
    .action_i   (cmd_q.action),
    .position_i (cmd_q.position),
    .occ_i      (occ),
    .op_o       (op),
    .at_o       (at)
  );

  iol_cells #(
    .CAPACITY (CAPACITY)
  ) u_cells (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (advance),
    .op_i       (op),
    .at_i       (at),
    .val_i      (cmd_q.item_value),
    .occ_o      (occ),
    .occ_next_o (occ_next),
    .removed_o  (removed),
    .front_o    (front),
    .end_o      (last)
  );

  always_comb begin
    rsp_d.removed_value = removed;
    rsp_d.status        = op.status;
    rsp_d.entry_count   = CNT_W'(occ_next);  // count masked to field width
    rsp_d.front_value   = front;
    rsp_d.end_value     = last;
  end

  always_comb begin
    rsp_vld_d = rsp_vld_q;
    if (advance) rsp_vld_d = 1'b1;
    else if (rsp_o.ready) rsp_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_vld_q <= 1'b0;
    end else begin
      rsp_vld_q <= rsp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid = rsp_vld_q;
  assign rsp_o.data  = rsp_q;

  // ---------------------------------------------------------------------------
  // assertions

  // an opened slot adds exactly one entry
  a_open_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && op.kind == OP_OPEN |=> occ == $past(occ) + OCC_W'(1))
    else $error("open did not grow count by one");

  // a rejected command leaves the count alone
  a_error_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && op.status != ST_OK |=> occ == $past(occ))
    else $error("rejected command changed count");

  // count never passes the capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> occ <= OCC_W'(CAPACITY))
    else $error("count exceeded capacity");

  // an empty-list error returns no value
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_vld_q && rsp_q.status == ST_EMPTY |-> rsp_q.removed_value == '0)
    else $error("empty error returned a value");

endmodule
